// File: rtl/clsr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_pkg
// Constants and types shared by the combined LCG shuffle generator.
// ----------------------------------------------------------------------------
package clsr_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int WARM_STEPS  = TABLE_DEPTH + 8;
  localparam int CNT_W       = $clog2(WARM_STEPS);
  localparam int IDX_SHIFT   = 31 - IDX_W;

  localparam logic [30:0] MOD_ONE  = 31'd2147483563;
  localparam logic [15:0] MUL_ONE  = 16'd40014;
  localparam logic [7:0]  FOLD_ONE = 8'd85;
  localparam logic [30:0] MOD_TWO  = 31'd2147483399;
  localparam logic [15:0] MUL_TWO  = 16'd40692;
  localparam logic [7:0]  FOLD_TWO = 8'd249;

  localparam logic [30:0] WRAP_ADD  = 31'd2147483562;
  localparam logic [30:0] INDEX_DIV = 31'(1 + 2147483562 / TABLE_DEPTH);

  localparam logic signed [31:0] SEED_RESET   = -32'sd184503872;
  localparam logic [30:0]        SECOND_RESET = 31'd123456789;

  typedef struct packed {
    logic        vld;
    logic        sel;
    logic [30:0] x;
  } lcg_req_t;

  typedef struct packed {
    logic        vld;
    logic        sel;
    logic [30:0] val;
  } lcg_rsp_t;

endpackage
`default_nettype wire

// File: rtl/clsr_lcg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clsr_lcg
// Shared three-stage modular multiply unit: x * a mod m for either generator,
// using the 2^31 - c form of each modulus (multiply, fold, fold and reduce).
// ----------------------------------------------------------------------------
module clsr_lcg
  import clsr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire lcg_req_t req,
  output lcg_rsp_t      rsp
);

  logic        v1_r, v2_r, v3_r;
  logic        s1_r, s2_r, s3_r;
  logic [46:0] prod_r;
  logic [31:0] fold_r;
  logic [30:0] res_r;

  logic [15:0] mul_sel;
  logic [7:0]  fold_c2;
  logic [7:0]  fold_c3;
  logic [30:0] mod_c3;
  logic [31:0] fold_nxt;
  logic [31:0] t_sum;
  logic [30:0] res_nxt;

  always_comb begin
    mul_sel  = req.sel ? MUL_TWO : MUL_ONE;
    fold_c2  = s1_r ? FOLD_TWO : FOLD_ONE;
    fold_c3  = s2_r ? FOLD_TWO : FOLD_ONE;
    mod_c3   = s2_r ? MOD_TWO : MOD_ONE;
    fold_nxt = {1'b0, prod_r[30:0]} + ({16'd0, prod_r[46:31]} * {24'd0, fold_c2});
    t_sum    = {1'b0, fold_r[30:0]} + (fold_r[31] ? {24'd0, fold_c3} : 32'd0);
    if (t_sum >= {1'b0, mod_c3}) begin
      res_nxt = 31'(t_sum - {1'b0, mod_c3});
    end else begin
      res_nxt = t_sum[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r   <= req.sel;
    prod_r <= {16'd0, req.x} * {31'd0, mul_sel};
    s2_r   <= s1_r;
    fold_r <= fold_nxt;
    s3_r   <= s2_r;
    res_r  <= res_nxt;
  end

  assign rsp.vld = v3_r;
  assign rsp.sel = s3_r;
  assign rsp.val = res_r;

endmodule
`default_nettype wire

// File: rtl/combined_lcg_shuffle_rng.sv
`default_nettype none
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Two combined multiplicative LCGs with a shuffle table; returns integers in
// 1..2147483562 (fraction = value / 2147483563, formed downstream).
// ----------------------------------------------------------------------------
// A request beat with advance set yields one value beat; a beat with advance
// clear is taken and yields nothing. A normal draw issues the two generator
// steps in turn into the three-stage shared modular multiply unit, waits for
// its second result, then updates the table and registers the value. A new
// request is taken only once the previous draw has finished; a draw holds in
// its final state while the previous value beat waits. When the first
// generator is zero or negative (after reset or a non-positive seed write) the
// draw first runs the warm-up: 40 dependent generator steps through the same
// unit, each issued and awaited in turn. Seed writes on the cfg channel are
// always ready and belong between draws.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng
  import clsr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,   // seed[31:0]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // advance[0], zero [7:1]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // value[30:0], zero [31]
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WISSUE = 3'd1;
  localparam logic [2:0] S_WWAIT  = 3'd2;
  localparam logic [2:0] S_DISS1  = 3'd3;
  localparam logic [2:0] S_DISS2  = 3'd4;
  localparam logic [2:0] S_DWAIT  = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic signed [31:0] fg_r, fg_nxt;
  logic [30:0]        g2_r, g2_nxt;
  logic [30:0]        last_r, last_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [30:0]        out_val_r, out_val_nxt;

  logic [30:0]            mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ent_vld_r;
  logic [30:0]            rd_r;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [30:0]            wr_data;

  lcg_req_t req;
  lcg_rsp_t rsp;

  logic        in_acc;
  logic        out_free;
  logic [30:0] mag;
  logic [IDX_W:0] j_lo, j_hi;
  logic [31:0] bound;
  logic [30:0] entry;
  logic [32:0] diff;
  logic [32:0] wrapped;

  clsr_lcg u_lcg (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_val_r};
  assign out_free   = !out_vld_r || out_tready;

  always_comb begin
    req.vld = state_r inside {S_WISSUE, S_DISS1, S_DISS2};
    req.sel = (state_r == S_DISS2);
    req.x   = (state_r == S_DISS2) ? g2_r : fg_r[30:0];
  end

  always_comb begin
    if (fg_r == 32'sh8000_0000) begin
      mag = 31'h7FFF_FFFF;
    end else if (fg_r == 32'sd0) begin
      mag = 31'd1;
    end else begin
      mag = 31'(-fg_r);
    end
    j_lo  = {1'b0, last_r[30:IDX_SHIFT]};
    bound = 32'((j_lo + 1'b1) * INDEX_DIV);
    j_hi  = ({1'b0, last_r} >= bound) ? j_lo + 1'b1 : j_lo;
    entry   = ent_vld_r[j_r] ? rd_r : 31'd0;
    diff    = {2'b0, entry} - {2'b0, g2_r};
    wrapped = (diff[32] || diff == 33'd0) ? diff + {2'b0, WRAP_ADD} : diff;
  end

  always_comb begin
    state_nxt   = state_r;
    fg_nxt      = fg_r;
    g2_nxt      = g2_r;
    last_nxt    = last_r;
    cnt_nxt     = cnt_r;
    j_nxt       = j_r;
    out_vld_nxt = out_vld_r && !out_tready;
    out_val_nxt = out_val_r;
    wr_en       = 1'b0;
    wr_addr     = cnt_r[IDX_W-1:0];
    wr_data     = rsp.val;
    if (rsp.vld && !rsp.sel) begin
      fg_nxt = {1'b0, rsp.val};
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_tdata[0]) begin
          if (fg_r[31] || fg_r == 32'sd0) begin
            fg_nxt    = {1'b0, mag};
            g2_nxt    = mag;
            cnt_nxt   = CNT_W'(WARM_STEPS - 1);
            state_nxt = S_WISSUE;
          end else begin
            state_nxt = S_DISS1;
          end
        end
      end
      S_WISSUE: begin
        state_nxt = S_WWAIT;
      end
      S_WWAIT: begin
        if (rsp.vld) begin
          if (cnt_r < CNT_W'(TABLE_DEPTH)) begin
            wr_en = 1'b1;
          end
          if (cnt_r == '0) begin
            last_nxt  = rsp.val;
            state_nxt = S_DISS1;
          end else begin
            cnt_nxt   = cnt_r - 1'b1;
            state_nxt = S_WISSUE;
          end
        end
      end
      S_DISS1: begin
        j_nxt     = (j_hi >= (IDX_W+1)'(TABLE_DEPTH)) ? IDX_W'(TABLE_DEPTH - 1)
                                                     : j_hi[IDX_W-1:0];
        state_nxt = S_DISS2;
      end
      S_DISS2: begin
        state_nxt = S_DWAIT;
      end
      S_DWAIT: begin
        if (rsp.vld && rsp.sel) begin
          g2_nxt    = rsp.val;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          wr_en       = 1'b1;
          wr_addr     = j_r;
          wr_data     = fg_r[30:0];
          last_nxt    = wrapped[30:0];
          out_val_nxt = wrapped[30:0];
          out_vld_nxt = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_valid && cfg_ready) begin
      fg_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fg_r      <= SEED_RESET;
      g2_r      <= SECOND_RESET;
      last_r    <= 31'd0;
      cnt_r     <= '0;
      j_r       <= '0;
      out_vld_r <= 1'b0;
      ent_vld_r <= '0;
    end else begin
      state_r   <= state_nxt;
      fg_r      <= fg_nxt;
      g2_r      <= g2_nxt;
      last_r    <= last_nxt;
      cnt_r     <= cnt_nxt;
      j_r       <= j_nxt;
      out_vld_r <= out_vld_nxt;
      if (wr_en) begin
        ent_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_val_r <= out_val_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[j_r];
  end

endmodule
`default_nettype wire
